// ===== rtl/core/button_gesture_classifier_macros.svh =====
// Assertion macros used by the button gesture classifier top level.
`ifndef BUTTON_GESTURE_CLASSIFIER_MACROS_SVH
`define BUTTON_GESTURE_CLASSIFIER_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define BGC_ASSERT_HOLDS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check that a cause always comes with its consequence in the same cycle.
`define BGC_ASSERT_IMPLIES(label, cause, effect, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cause) |-> (effect)) \
      else $error(msg);

`endif

// ===== rtl/core/bgc_pkg.sv =====
// Types and constants of the button gesture classifier.
package bgc_pkg;

   localparam int TIME_WIDTH      = 32;
   localparam int DEBOUNCE_WIDTH  = 10;
   localparam int LIMIT_WIDTH     = 16;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int REQ_DATA_WIDTH  = 40;
   localparam int RSP_DATA_WIDTH  = 8;

   // Event kinds carried on the request tuser bit
   localparam logic OP_EDGE = 1'b0;
   localparam logic OP_POLL = 1'b1;

   // Register indexes on the configuration channel
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DEBOUNCE = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_LONG     = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_WINDOW   = 2'd2;

   // Reset values of the registers
   localparam logic [DEBOUNCE_WIDTH-1:0] DEBOUNCE_RESET = 10'd8;
   localparam logic [LIMIT_WIDTH-1:0]    LONG_RESET     = 16'd600;
   localparam logic [LIMIT_WIDTH-1:0]    WINDOW_RESET   = 16'd250;

   typedef struct packed {
      logic [DEBOUNCE_WIDTH-1:0] debounce_ms;
      logic [LIMIT_WIDTH-1:0]    long_press_ms;
      logic [LIMIT_WIDTH-1:0]    double_window_ms;
   } cfg_type;

   typedef struct packed {
      logic                  operation;
      logic                  level_pressed;
      logic [TIME_WIDTH-1:0] now_ms;
   } event_type;

   typedef struct packed {
      logic active;
      logic long_press;
      logic double_press;
      logic single_press;
   } result_type;

endpackage

// ===== rtl/core/bgc_csr.sv =====
// Configuration registers of the button gesture classifier.
module bgc_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [bgc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [bgc_pkg::CSR_DATA_WIDTH-1:0]    csr_data,
   output bgc_pkg::cfg_type                      cfg
);

   bgc_pkg::cfg_type cfg_ff;
   bgc_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            bgc_pkg::REG_DEBOUNCE:
               cfg_in.debounce_ms = csr_data[bgc_pkg::DEBOUNCE_WIDTH-1:0];
            bgc_pkg::REG_LONG:
               cfg_in.long_press_ms = csr_data[bgc_pkg::LIMIT_WIDTH-1:0];
            bgc_pkg::REG_WINDOW:
               cfg_in.double_window_ms = csr_data[bgc_pkg::LIMIT_WIDTH-1:0];
            default: ; // drop writes beyond the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms      <= bgc_pkg::DEBOUNCE_RESET;
         cfg_ff.long_press_ms    <= bgc_pkg::LONG_RESET;
         cfg_ff.double_window_ms <= bgc_pkg::WINDOW_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/core/bgc_core.sv =====
// Press tracking state and the edge/poll classification logic.
module bgc_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  bgc_pkg::event_type   evt,
   input  bgc_pkg::cfg_type     cfg,
   output bgc_pkg::result_type  result
);

   logic [bgc_pkg::TIME_WIDTH-1:0] last_edge_ff, last_edge_in;
   logic [bgc_pkg::TIME_WIDTH-1:0] press_time_ff, press_time_in;
   logic [bgc_pkg::TIME_WIDTH-1:0] first_rel_ff, first_rel_in;
   logic is_held_ff, is_held_in;
   logic awaiting_ff, awaiting_in;
   logic dbl_pending_ff, dbl_pending_in;
   logic long_consumed_ff, long_consumed_in;
   logic long_fired_ff, long_fired_in;

   logic [bgc_pkg::TIME_WIDTH-1:0] since_edge;
   logic [bgc_pkg::TIME_WIDTH-1:0] since_press;
   logic [bgc_pkg::TIME_WIDTH-1:0] since_first;
   logic [bgc_pkg::TIME_WIDTH-1:0] debounce_ext;
   logic [bgc_pkg::TIME_WIDTH-1:0] long_ext;
   logic [bgc_pkg::TIME_WIDTH-1:0] window_ext;
   logic edge_ok;
   logic hold_short;
   logic within_window;
   logic past_long;
   logic past_window;
   logic fire_long;

   // Differences wrap modulo 2^32
   assign since_edge  = evt.now_ms - last_edge_ff;
   assign since_press = evt.now_ms - press_time_ff;
   assign since_first = evt.now_ms - first_rel_ff;

   assign debounce_ext = {{(bgc_pkg::TIME_WIDTH-bgc_pkg::DEBOUNCE_WIDTH){1'b0}},
                          cfg.debounce_ms};
   assign long_ext     = {{(bgc_pkg::TIME_WIDTH-bgc_pkg::LIMIT_WIDTH){1'b0}},
                          cfg.long_press_ms};
   assign window_ext   = {{(bgc_pkg::TIME_WIDTH-bgc_pkg::LIMIT_WIDTH){1'b0}},
                          cfg.double_window_ms};

   assign edge_ok       = since_edge >= debounce_ext;
   assign hold_short    = since_press < long_ext;
   assign within_window = since_first <= window_ext;
   assign past_long     = since_press > long_ext;
   assign past_window   = since_first > window_ext;
   assign fire_long     = is_held_ff && !long_fired_ff && past_long;

   always_comb begin
      last_edge_in     = last_edge_ff;
      press_time_in    = press_time_ff;
      first_rel_in     = first_rel_ff;
      is_held_in       = is_held_ff;
      awaiting_in      = awaiting_ff;
      dbl_pending_in   = dbl_pending_ff;
      long_consumed_in = long_consumed_ff;
      long_fired_in    = long_fired_ff;
      result           = '0;

      if (evt.operation == bgc_pkg::OP_POLL) begin
         result.active = is_held_ff || awaiting_ff || dbl_pending_ff;
         if (fire_long) begin
            result.long_press = 1'b1;
            long_fired_in     = 1'b1;
            awaiting_in       = 1'b0;
            dbl_pending_in    = 1'b0;
            long_consumed_in  = 1'b1;
         end else if (!is_held_ff && long_fired_ff) begin
            long_fired_in = 1'b0;
         end
         // A double seen before this poll is reported even when a long press fires
         if (dbl_pending_ff) begin
            result.double_press = 1'b1;
            dbl_pending_in      = 1'b0;
            awaiting_in         = 1'b0;
         end else if (awaiting_ff && !is_held_ff && past_window) begin
            result.single_press = 1'b1;
            awaiting_in         = 1'b0;
         end
      end else if (edge_ok) begin
         last_edge_in = evt.now_ms;
         if (evt.level_pressed) begin
            is_held_in    = 1'b1;
            press_time_in = evt.now_ms;
         end else begin
            is_held_in = 1'b0;
            if (long_consumed_ff) begin
               // swallow the release that ends a long press
               long_consumed_in = 1'b0;
               awaiting_in      = 1'b0;
            end else if (hold_short) begin
               if (awaiting_ff && within_window) begin
                  dbl_pending_in = 1'b1;
                  awaiting_in    = 1'b0;
               end else begin
                  awaiting_in  = 1'b1;
                  first_rel_in = evt.now_ms;
               end
            end else begin
               awaiting_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_edge_ff     <= '0;
         press_time_ff    <= '0;
         first_rel_ff     <= '0;
         is_held_ff       <= 1'b0;
         awaiting_ff      <= 1'b0;
         dbl_pending_ff   <= 1'b0;
         long_consumed_ff <= 1'b0;
         long_fired_ff    <= 1'b0;
      end else if (advance) begin
         last_edge_ff     <= last_edge_in;
         press_time_ff    <= press_time_in;
         first_rel_ff     <= first_rel_in;
         is_held_ff       <= is_held_in;
         awaiting_ff      <= awaiting_in;
         dbl_pending_ff   <= dbl_pending_in;
         long_consumed_ff <= long_consumed_in;
         long_fired_ff    <= long_fired_in;
      end
   end

endmodule

// ===== rtl/core/button_gesture_classifier.sv =====
// Button gesture classifier: single, double and long press detection.
//
// Request channel (req_): one event per transfer. tuser is the event kind,
// 0 for a pin edge and 1 for a poll. tdata carries the pin level in bit 0
// and the 32-bit millisecond timestamp in bits 32:1.
// Response channel (rsp_): exactly one result per request, in order. Edge
// events give an all-zero result; polls report single, double and long
// presses and whether the button was active before the poll.
// Configuration channel (csr_): index 0 debounce, 1 long-press limit,
// 2 double-press window; other indexes are ignored. Always ready.
// A request taken is held in the input register, classified combinationally and
// stored in the result register that drives rsp_. Throughput: one event per cycle while
// rsp_ is not stalled, set by the single combinational pass between the two registers.
// A stalled receiver holds the result register; one further request is
// held in the input register and then req_tready drops.
// Reset clears all press tracking and loads the default register values
// (8, 600 and 250 ms).
`include "button_gesture_classifier_macros.svh"

module button_gesture_classifier (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [bgc_pkg::REQ_DATA_WIDTH-1:0]    req_tdata,  // level_pressed, now_ms, zero pad
   input  logic                                  req_tuser,  // operation
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [bgc_pkg::RSP_DATA_WIDTH-1:0]    rsp_tdata,  // single, double, long, active, pad
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [bgc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [bgc_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);

   bgc_pkg::cfg_type    cfg;
   bgc_pkg::event_type  evt_ff;
   bgc_pkg::result_type result;
   bgc_pkg::result_type rsp_ff;

   logic in_valid_ff, in_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic advance;
   logic req_fire;

   bgc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bgc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .evt     (evt_ff),
      .cfg     (cfg),
      .result  (result)
   );

   // Move the held event into the result register when that register frees
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   assign in_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(bgc_pkg::RSP_DATA_WIDTH-4){1'b0}}, rsp_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_fire) begin
         evt_ff.operation     <= req_tuser;
         evt_ff.level_pressed <= req_tdata[0];
         evt_ff.now_ms        <= req_tdata[bgc_pkg::TIME_WIDTH:1];
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   `BGC_ASSERT_IMPLIES(a_stall_only_when_full, !req_tready, rsp_valid_ff && !rsp_tready && in_valid_ff, "request stalled without a full pipeline")
   `BGC_ASSERT_HOLDS(a_single_alone, !(rsp_valid_ff && rsp_ff.single_press && (rsp_ff.double_press || rsp_ff.long_press)), "single press reported with another gesture")
   `BGC_ASSERT_IMPLIES(a_gesture_active, rsp_valid_ff && (rsp_ff.single_press || rsp_ff.double_press || rsp_ff.long_press), rsp_ff.active, "gesture reported while inactive")

endmodule

// ===== bench/button_gesture_classifier_tb.sv =====
// Self-checking bench for the button gesture classifier: gesture streams against a local predictor.
module button_gesture_classifier_tb;

   localparam int CLK_HALF       = 10;
   localparam int LIMIT_CYCLES   = 400_000;
   localparam int PHASE_ITEMS    = 155;
   localparam int RX_HOLD_CYCLES = 300;
   localparam int TIME_BITS      = bgc_pkg::TIME_WIDTH;
   localparam int PAD_WIDTH      = bgc_pkg::REQ_DATA_WIDTH - bgc_pkg::TIME_WIDTH - 1;
   localparam logic [bgc_pkg::CSR_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [bgc_pkg::REQ_DATA_WIDTH-1:0]  req_tdata  = '0;  // level_pressed, now_ms, zero pad
   logic                                req_tuser  = bgc_pkg::OP_EDGE;  // operation
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [bgc_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata;  // single, double, long, active, pad
   logic                                csr_valid  = 1'b0;
   logic                                csr_ready;
   logic [bgc_pkg::CSR_INDEX_WIDTH-1:0] csr_index  = bgc_pkg::REG_DEBOUNCE;
   logic [bgc_pkg::CSR_DATA_WIDTH-1:0]  csr_data   = '0;

   button_gesture_classifier i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // Stimulus and scoreboard storage
   bgc_pkg::event_type  pending_events[$];
   bgc_pkg::result_type expected_results[$];
   logic        req_fired = 1'b0;
   logic        rx_hold = 1'b0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned offered = 0;
   int unsigned checked = 0;
   int unsigned error_count = 0;
   int unsigned seen_single = 0;
   int unsigned seen_double = 0;
   int unsigned seen_long = 0;
   int unsigned settings_used = 1;

   // Timing plan for the generator, mirrors the limits last written
   logic [bgc_pkg::TIME_WIDTH-1:0] stim_ms = '0;
   int unsigned plan_dbnc = 8;
   int unsigned plan_long = 600;
   int unsigned plan_win  = 250;

   // Predictor copy of the configuration and press tracking
   logic [bgc_pkg::DEBOUNCE_WIDTH-1:0] debounce_cfg;
   logic [bgc_pkg::LIMIT_WIDTH-1:0]    long_cfg;
   logic [bgc_pkg::LIMIT_WIDTH-1:0]    window_cfg;
   logic [bgc_pkg::TIME_WIDTH-1:0]     last_edge_ms;
   logic [bgc_pkg::TIME_WIDTH-1:0]     press_ms;
   logic [bgc_pkg::TIME_WIDTH-1:0]     release_ms;
   logic btn_held, second_awaited, double_armed, long_swallow, long_latched;

   function automatic bgc_pkg::result_type classify_event(bgc_pkg::event_type ev);
      bgc_pkg::result_type            r;
      logic [bgc_pkg::TIME_WIDTH-1:0] since_edge;
      logic [bgc_pkg::TIME_WIDTH-1:0] since_press;
      logic [bgc_pkg::TIME_WIDTH-1:0] since_release;
      logic                           was_held, was_waiting, had_double;
      r = '0;
      since_edge    = ev.now_ms - last_edge_ms;
      since_press   = ev.now_ms - press_ms;
      since_release = ev.now_ms - release_ms;
      if (ev.operation == bgc_pkg::OP_EDGE) begin
         // drop edges that come too soon after the last accepted one
         if (since_edge >= TIME_BITS'(debounce_cfg)) begin
            last_edge_ms = ev.now_ms;
            if (ev.level_pressed) begin
               btn_held = 1'b1;
               press_ms = ev.now_ms;
            end else begin
               btn_held = 1'b0;
               if (long_swallow) begin
                  long_swallow   = 1'b0;
                  second_awaited = 1'b0;
               end else if (since_press < TIME_BITS'(long_cfg)) begin
                  if (second_awaited && since_release <= TIME_BITS'(window_cfg)) begin
                     double_armed   = 1'b1;
                     second_awaited = 1'b0;
                  end else begin
                     second_awaited = 1'b1;
                     release_ms     = ev.now_ms;
                  end
               end else begin
                  second_awaited = 1'b0;
               end
            end
         end
      end else begin
         was_held    = btn_held;
         was_waiting = second_awaited;
         had_double  = double_armed;
         if (was_held) begin
            if (!long_latched && since_press > TIME_BITS'(long_cfg)) begin
               r.long_press   = 1'b1;
               long_latched   = 1'b1;
               second_awaited = 1'b0;
               double_armed   = 1'b0;
               long_swallow   = 1'b1;
            end
         end else begin
            long_latched = 1'b0;
         end
         // a double seen before this poll still goes out, even beside a long press
         if (had_double) begin
            r.double_press = 1'b1;
            double_armed   = 1'b0;
            second_awaited = 1'b0;
         end else if (was_waiting && !was_held && since_release > TIME_BITS'(window_cfg)) begin
            r.single_press = 1'b1;
            second_awaited = 1'b0;
         end
         r.active = was_held | was_waiting | had_double;
      end
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      if (error_count < 40) $display("mismatch: %s", msg);
      error_count++;
   endtask

   // Sample at the rising edge: predict on accepted events, check accepted results
   always @(posedge clock) begin
      bgc_pkg::event_type  ev;
      bgc_pkg::result_type want, got;
      req_fired <= !reset && req_tvalid && req_tready;
      if (reset) begin
         debounce_cfg   = bgc_pkg::DEBOUNCE_RESET;
         long_cfg       = bgc_pkg::LONG_RESET;
         window_cfg     = bgc_pkg::WINDOW_RESET;
         last_edge_ms   = '0;
         press_ms       = '0;
         release_ms     = '0;
         btn_held       = 1'b0;
         second_awaited = 1'b0;
         double_armed   = 1'b0;
         long_swallow   = 1'b0;
         long_latched   = 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               bgc_pkg::REG_DEBOUNCE:
                  debounce_cfg = csr_data[bgc_pkg::DEBOUNCE_WIDTH-1:0];
               bgc_pkg::REG_LONG:     long_cfg   = csr_data;
               bgc_pkg::REG_WINDOW:   window_cfg = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            ev.operation     = req_tuser;
            ev.level_pressed = req_tdata[0];
            ev.now_ms        = req_tdata[bgc_pkg::TIME_WIDTH:1];
            expected_results = {expected_results, classify_event(ev)};
         end
         if (rsp_tvalid && rsp_tready) begin
            got = bgc_pkg::result_type'(rsp_tdata[3:0]);
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("result with nothing outstanding: %b", got));
            end else begin
               want = expected_results.pop_front();
               if (got.single_press !== want.single_press)
                  report_mismatch($sformatf("result %0d single_press: expected %b got %b",
                                            checked, want.single_press, got.single_press));
               if (got.double_press !== want.double_press)
                  report_mismatch($sformatf("result %0d double_press: expected %b got %b",
                                            checked, want.double_press, got.double_press));
               if (got.long_press !== want.long_press)
                  report_mismatch($sformatf("result %0d long_press: expected %b got %b",
                                            checked, want.long_press, got.long_press));
               if (got.active !== want.active)
                  report_mismatch($sformatf("result %0d active: expected %b got %b",
                                            checked, want.active, got.active));
               seen_single += want.single_press;
               seen_double += want.double_press;
               seen_long   += want.long_press;
            end
            checked++;
         end
      end
   end

   // Drive at the falling edge: next event once the last transfer has gone
   always @(negedge clock) begin
      bgc_pkg::event_type ev;
      if (!reset) begin
         if (!req_tvalid || req_fired) begin
            if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               ev = pending_events.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= ev.operation;
               req_tdata  <= {{PAD_WIDTH{1'b0}}, ev.now_ms, ev.level_pressed};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic offer_after(int unsigned gap, logic op, logic lvl);
      bgc_pkg::event_type ev;
      stim_ms          = stim_ms + gap;
      ev.operation     = op;
      ev.level_pressed = lvl;
      ev.now_ms        = stim_ms;
      pending_events   = {pending_events, ev};
      offered++;
   endtask

   task automatic offer_at(logic [bgc_pkg::TIME_WIDTH-1:0] at_ms, logic op, logic lvl);
      stim_ms = at_ms;
      offer_after(0, op, lvl);
   endtask

   // Spread around a threshold: on it, below it or past it
   function automatic int unsigned around(int unsigned lim);
      case ($urandom_range(3))
         0: return (lim < 2) ? $urandom_range(lim + 2) : lim - 2 + $urandom_range(4);
         1: return $urandom_range(lim);
         default: return lim + 1 + $urandom_range(lim / 2 + 8);
      endcase
   endfunction

   function automatic int unsigned edge_gap();
      return ($urandom_range(9) == 0) ? $urandom_range(plan_dbnc)
                                      : plan_dbnc + $urandom_range(plan_dbnc + 16);
   endfunction

   function automatic int unsigned hold_time();
      return ($urandom_range(3) == 0) ? around(plan_long)
                                      : plan_dbnc + $urandom_range(plan_long);
   endfunction

   task automatic add_gesture();
      int unsigned kind;
      int unsigned burst;
      kind  = $urandom_range(9);
      burst = 1 + $urandom_range(3);
      case (kind)
         0, 1, 2: begin  // lone press, short or near the long limit, polled either side of the window
            offer_after(edge_gap(), bgc_pkg::OP_EDGE, 1'b1);
            offer_after(hold_time(), bgc_pkg::OP_EDGE, 1'b0);
            offer_after(around(plan_win), bgc_pkg::OP_POLL, 1'($urandom_range(1)));
            offer_after(around(plan_win / 2), bgc_pkg::OP_POLL, 1'($urandom_range(1)));
         end
         3, 4, 5: begin  // two quick presses
            offer_after(edge_gap(), bgc_pkg::OP_EDGE, 1'b1);
            offer_after(plan_dbnc + $urandom_range(plan_win / 2), bgc_pkg::OP_EDGE, 1'b0);
            offer_after(plan_dbnc + $urandom_range(plan_win / 2), bgc_pkg::OP_EDGE, 1'b1);
            offer_after(plan_dbnc + $urandom_range(plan_win / 2 + 2), bgc_pkg::OP_EDGE, 1'b0);
            offer_after($urandom_range(plan_win + 4), bgc_pkg::OP_POLL, 1'($urandom_range(1)));
         end
         6, 7: begin  // hold around the long limit, then let go
            offer_after(edge_gap(), bgc_pkg::OP_EDGE, 1'b1);
            offer_after(around(plan_long), bgc_pkg::OP_POLL, 1'($urandom_range(1)));
            offer_after($urandom_range(plan_long / 4 + 4), bgc_pkg::OP_POLL,
                        1'($urandom_range(1)));
            offer_after(edge_gap(), bgc_pkg::OP_EDGE, 1'b0);
            offer_after(around(plan_win), bgc_pkg::OP_POLL, 1'($urandom_range(1)));
         end
         default: begin  // stray events, now and then at an arbitrary timestamp
            repeat (burst) begin
               if ($urandom_range(7) == 0) stim_ms = $urandom();
               offer_after($urandom_range(2 * plan_dbnc + 8), 1'($urandom_range(1)),
                           1'($urandom_range(1)));
            end
         end
      endcase
   endtask

   task automatic write_reg(logic [bgc_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            logic [bgc_pkg::CSR_DATA_WIDTH-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_limits(logic [bgc_pkg::CSR_DATA_WIDTH-1:0] dbnc,
                             logic [bgc_pkg::LIMIT_WIDTH-1:0] lng,
                             logic [bgc_pkg::LIMIT_WIDTH-1:0] win);
      write_reg(bgc_pkg::REG_DEBOUNCE, dbnc);
      write_reg(bgc_pkg::REG_LONG, lng);
      write_reg(bgc_pkg::REG_WINDOW, win);
      plan_dbnc = dbnc[bgc_pkg::DEBOUNCE_WIDTH-1:0];
      plan_long = lng;
      plan_win  = win;
      settings_used++;
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_events.size() != 0 || req_tvalid || expected_results.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   initial begin
      int unsigned target;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset limits (8, 600, 250)
      offer_at(32'd3, bgc_pkg::OP_EDGE, 1'b1);        // bounce right after reset
      offer_at(32'd5, bgc_pkg::OP_POLL, 1'b0);
      offer_at(32'd100, bgc_pkg::OP_EDGE, 1'b1);
      offer_at(32'd200, bgc_pkg::OP_EDGE, 1'b0);
      offer_at(32'd451, bgc_pkg::OP_POLL, 1'b1);      // window just run out
      offer_at(32'd1000, bgc_pkg::OP_EDGE, 1'b1);
      offer_at(32'd1100, bgc_pkg::OP_EDGE, 1'b0);
      offer_at(32'd1200, bgc_pkg::OP_EDGE, 1'b1);
      offer_at(32'd1300, bgc_pkg::OP_EDGE, 1'b0);
      offer_at(32'd1301, bgc_pkg::OP_POLL, 1'b0);
      offer_at(32'd2000, bgc_pkg::OP_EDGE, 1'b1);
      offer_at(32'd2003, bgc_pkg::OP_EDGE, 1'b0);     // bounce while held
      offer_at(32'd2601, bgc_pkg::OP_POLL, 1'b0);     // just past the long limit
      offer_at(32'd2800, bgc_pkg::OP_EDGE, 1'b0);     // swallowed after the long press
      offer_at(32'd3200, bgc_pkg::OP_POLL, 1'b0);
      offer_at(32'd4000, bgc_pkg::OP_EDGE, 1'b1);
      offer_at(32'd4050, bgc_pkg::OP_EDGE, 1'b0);
      offer_at(32'd4100, bgc_pkg::OP_EDGE, 1'b1);
      offer_at(32'd4150, bgc_pkg::OP_EDGE, 1'b0);
      offer_at(32'd4200, bgc_pkg::OP_EDGE, 1'b1);
      offer_at(32'd4801, bgc_pkg::OP_POLL, 1'b0);     // long press beside the pending double
      offer_at(32'd5500, bgc_pkg::OP_EDGE, 1'b0);
      offer_at(32'd6000, bgc_pkg::OP_EDGE, 1'b1);
      offer_at(32'd6100, bgc_pkg::OP_EDGE, 1'b1);     // repeated press restarts the hold
      offer_at(32'd6700, bgc_pkg::OP_EDGE, 1'b0);     // release exactly at the long limit
      offer_at(32'd7000, bgc_pkg::OP_EDGE, 1'b0);     // release while not held
      offer_at(32'hFFFF_FFFF, bgc_pkg::OP_EDGE, 1'b1);
      offer_at(32'd700, bgc_pkg::OP_POLL, 1'b1);      // hold measured across the wrap
      wait_drained();

      for (int phase = 0; phase < 6; phase++) begin
         stim_ms = $urandom();
         case (phase)
            0: begin
               send_idle_pct = 0;  recv_stall_pct = 0;
               set_limits(16'd20, 16'd300, 16'd120);
            end
            1: begin
               send_idle_pct = 83; recv_stall_pct = 0;
               set_limits(16'd0, 16'd0, 16'd0);
            end
            2: begin
               send_idle_pct = 0;  recv_stall_pct = 83;
               set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF);  // debounce upper bits masked
               stim_ms = 32'hFFFF_FFFF - 32'($urandom_range(200_000));
            end
            3: begin
               send_idle_pct = 13; recv_stall_pct = 13;
               write_reg(REG_UNUSED, 16'($urandom()));
               set_limits(16'(($urandom_range(63) << 10) | $urandom_range(40)),
                          16'($urandom_range(50, 2000)), 16'($urandom_range(20, 800)));
            end
            4: begin
               send_idle_pct = 0;  recv_stall_pct = 0;
               set_limits(16'd5, 16'd600, 16'd250);
               // hold the receiver off long enough for the block to back up
               fork
                  begin
                     rx_hold = 1'b1;
                     repeat (RX_HOLD_CYCLES) @(posedge clock);
                     rx_hold = 1'b0;
                  end
               join_none
            end
            default: begin
               send_idle_pct = 13; recv_stall_pct = 13;
               set_limits(16'($urandom_range(30)), 16'($urandom_range(100, 1500)),
                          16'($urandom_range(10, 600)));
            end
         endcase
         if (phase == 4) begin
            target = offered + PHASE_ITEMS / 2;
            while (offered < target) add_gesture();
            wait_drained();  // pause the sender until every result is back
         end
         target = offered + (phase == 4 ? PHASE_ITEMS / 2 : PHASE_ITEMS);
         while (offered < target) add_gesture();
         wait_drained();
      end

      repeat (10) @(posedge clock);
      $display("covered %0d events under %0d register settings, wrap and long back-pressure",
               checked, settings_used);
      $display("presses seen: %0d single, %0d double, %0d long", seen_single, seen_double,
               seen_long);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #(LIMIT_CYCLES * 2 * CLK_HALF);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
